// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/lkvt_pkg.sv =====
// Shared constants, codes and control types for the key/value table.
// No dependencies.
package lkvt_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_SET = 2'd0,
    ACT_GET = 2'd1,
    ACT_DEL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                  upd;
    logic                  append;
    logic                  del;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/lkvt_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on lkvt_pkg.
interface lkvt_req_if;
  import lkvt_pkg::*;

  logic                  valid;
  logic                  ready;
  action_t               action;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lkvt_rsp_if;
  import lkvt_pkg::*;

  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [VALUE_BITS-1:0] read_value;
  logic [COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

// ===== hw/rtl/lkvt_cell.sv =====
// One table slot: key/value registers, key compare and shift-down move.
// Depends on lkvt_pkg.
module lkvt_cell (
  input  logic                          clk,
  input  lkvt_pkg::cell_ctl_t           ctl,
  input  logic                          occ,
  input  logic                          tail,
  input  logic                          hit_in,
  input  logic [lkvt_pkg::VALUE_BITS-1:0] rd_in,
  input  logic [lkvt_pkg::KEY_BITS-1:0]   nb_key,
  input  logic [lkvt_pkg::VALUE_BITS-1:0] nb_val,
  output logic                          hit_out,
  output logic [lkvt_pkg::VALUE_BITS-1:0] rd_out,
  output logic                          match,
  output logic [lkvt_pkg::KEY_BITS-1:0]   key_q,
  output logic [lkvt_pkg::VALUE_BITS-1:0] val_q
);
  import lkvt_pkg::*;

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;

  assign match   = occ && (key_r == ctl.key);
  assign hit_out = hit_in | match;
  assign rd_out  = rd_in | (match ? val_r : '0);
  assign key_q   = key_r;
  assign val_q   = val_r;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    // on delete, the matching slot and all later ones pull from their upper neighbor
    if (ctl.del && hit_out && occ) begin
      key_nxt = nb_key;
      val_nxt = nb_val;
    end else if (ctl.upd && match) begin
      val_nxt = ctl.value;
    end else if (ctl.append && tail) begin
      key_nxt = ctl.key;
      val_nxt = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

// ===== hw/rtl/linear_key_value_table.sv =====
// Top level of the key/value table: request capture, cell row, result register.
// Depends on lkvt_pkg, lkvt_req_if/lkvt_rsp_if, lkvt_cell, assert_macros.svh.
//
//  channel   dir  fields                              handshake
//  in_req    in   action, key, value                  valid/ready
//  out_rsp   out  status, read_value, entry_count     valid/ready
//
// Each request goes through capture, then an execute step where all cells compare
// the key in parallel and apply set/append/shift-down at once.
// A new request is taken while a previous result still sits in the output register.
// The execute cycle waits only if the output register is still held by the sink.
// Reset (rst_n low, synchronous) empties the table; slot contents are not cleared.
module linear_key_value_table (
  input  logic       clk,
  input  logic       rst_n,
  lkvt_req_if.sink   in_req,
  lkvt_rsp_if.source out_rsp
);
  import lkvt_pkg::*;
  `include "assert_macros.svh"

  logic                  busy_r;
  action_t               act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  logic                  out_valid_r;
  status_t               status_r, status_nxt;
  logic [VALUE_BITS-1:0] rdval_r, rdval_nxt;
  logic [COUNT_W-1:0]    cnt_out_r;

  logic                  out_free, done, any_hit, full;
  logic                  upd, append, del;
  cell_ctl_t             ctl;

  logic [CAPACITY:0]     hit_c;
  logic [VALUE_BITS-1:0] rd_c [CAPACITY+1];
  logic [KEY_BITS-1:0]   key_c [CAPACITY];
  logic [VALUE_BITS-1:0] val_c [CAPACITY];
  logic [CAPACITY-1:0]   match_v;

  assign in_req.ready = !busy_r;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign done         = busy_r && out_free;
  assign any_hit      = hit_c[CAPACITY];
  assign full         = (count_r == COUNT_W'(CAPACITY));

  always_comb begin
    upd        = 1'b0;
    append     = 1'b0;
    del        = 1'b0;
    status_nxt = ST_OK;
    rdval_nxt  = '0;
    count_nxt  = count_r;
    case (act_r)
      ACT_SET: begin
        if (any_hit) begin
          upd = done;
        end else if (!full) begin
          append    = done;
          count_nxt = count_r + COUNT_W'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      ACT_GET: begin
        if (any_hit) rdval_nxt = rd_c[CAPACITY];
        else status_nxt = ST_NOT_FOUND;
      end
      ACT_DEL: begin
        if (any_hit) begin
          del       = done;
          count_nxt = count_r - COUNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl = '{upd: upd, append: append, del: del, key: key_r, value: value_r};

  assign hit_c[0] = 1'b0;
  assign rd_c[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nb_key;
    logic [VALUE_BITS-1:0] nb_val;
    if (i == CAPACITY - 1) begin : g_last
      assign nb_key = key_c[i];
      assign nb_val = val_c[i];
    end else begin : g_mid
      assign nb_key = key_c[i+1];
      assign nb_val = val_c[i+1];
    end

    lkvt_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (COUNT_W'(i) < count_r),
      .tail    (COUNT_W'(i) == count_r),
      .hit_in  (hit_c[i]),
      .rd_in   (rd_c[i]),
      .nb_key  (nb_key),
      .nb_val  (nb_val),
      .hit_out (hit_c[i+1]),
      .rd_out  (rd_c[i+1]),
      .match   (match_v[i]),
      .key_q   (key_c[i]),
      .val_q   (val_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        busy_r  <= 1'b1;
        act_r   <= in_req.action;
        key_r   <= in_req.key;
        value_r <= in_req.value;
      end else if (done) begin
        busy_r <= 1'b0;
      end

      if (done) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        status_r    <= status_nxt;
        rdval_r     <= rdval_nxt;
        cnt_out_r   <= count_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.read_value  = rdval_r;
  assign out_rsp.entry_count = cnt_out_r;

  `ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= COUNT_W'(CAPACITY))
  `ASSERT_IMP(a_single_match, clk, rst_n, busy_r, $onehot0(match_v))
  `ASSERT_NXT(a_done_result, clk, rst_n, done, out_valid_r && !busy_r)
  `ASSERT_NXT(a_append_grows, clk, rst_n, append, count_r == $past(count_r) + COUNT_W'(1))
  `ASSERT_NXT(a_delete_shrinks, clk, rst_n, del, count_r == $past(count_r) - COUNT_W'(1))

endmodule
